/* src/phl_pkg.sv */
package phl_pkg;

  localparam logic [31:0] GOLDEN   = 32'h9e3779b9;
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;

  localparam logic [2:0] MODE_ROT15 = 3'd0;
  localparam logic [2:0] MODE_ROTX  = 3'd1;
  localparam logic [2:0] MODE_ROTXY = 3'd2;
  localparam logic [2:0] MODE_WXYZ  = 3'd3;
  localparam logic [2:0] MODE_JENK  = 3'd4;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_SEED1  = 3'd1;
  localparam logic [2:0] REG_SEED2  = 3'd2;
  localparam logic [2:0] REG_SEED3  = 3'd3;
  localparam logic [2:0] REG_SEED4  = 3'd4;
  localparam logic [2:0] REG_HMASK  = 3'd5;
  localparam logic [2:0] REG_IMASK  = 3'd6;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // job handed from the hash front to the table back end
  typedef struct packed {
    logic        cmd;
    logic        coll;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] wdata;
    logic [23:0] waddr;
  } job_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} >> n;
    return t[31:0];
  endfunction

  // eight CRC bit steps
  function automatic logic [31:0] crc8(input logic [31:0] c);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

/* src/perfect_hash_index_lookup_core.sv */
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | command_i key_i entry_address_i entry_value_i
// out     | out_valid | out_stall | index_o collision_o
// cfg     | cfg_we_i  | -         | cfg_index_i cfg_data_i
//
// Front loads a key, then hashes it in 4 CRC steps of 8 bits or 3 Jenkins
// rounds, and takes no new item until the job is queued. Back end: a lookup
// reads the table twice through its single read port, then adds. Sustained
// lookup rate is set by the hasher. Reset is asynchronous, active low, clears
// control and the config registers; the table holds no reset value. A 2-item
// queue lets the sides stall apart.
module perfect_hash_index_lookup_core import phl_pkg::*; #(
  parameter int unsigned VERTEX_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command_i,
  input  logic [31:0] key_i,
  input  logic [15:0] entry_address_i,
  input  logic [31:0] entry_value_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] index_o,
  output logic        collision_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [2:0]  mode_q;
  logic [31:0] seed1_q, seed2_q, seed3_q, seed4_q, imask_q;
  logic [15:0] hmask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0; seed1_q <= '0; seed2_q <= '0; seed3_q <= '0;
      seed4_q <= '0; hmask_q <= '0; imask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:  mode_q  <= cfg_data_i[2:0];
        REG_SEED1: seed1_q <= cfg_data_i;
        REG_SEED2: seed2_q <= cfg_data_i;
        REG_SEED3: seed3_q <= cfg_data_i;
        REG_SEED4: seed4_q <= cfg_data_i;
        REG_HMASK: hmask_q <= cfg_data_i[15:0];
        REG_IMASK: imask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic job_valid, fifo_full, q_valid, q_pop;
  job_t job, q_job;

  phl_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .command_i, .key_i, .addr_i({8'd0, entry_address_i}), .value_i(entry_value_i),
    .mode_i(mode_q), .seed1_i(seed1_q), .seed2_i(seed2_q), .seed3_i(seed3_q),
    .seed4_i(seed4_q), .job_valid_o(job_valid), .job_ready_i(~fifo_full), .job_o(job)
  );

  phl_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(job_valid & ~fifo_full), .data_i(job),
    .full_o(fifo_full), .valid_o(q_valid), .pop_i(q_pop), .data_o(q_job)
  );

  phl_back #(.AW(VERTEX_ADDR_BITS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_pop_o(q_pop), .job_i(q_job),
    .hmask_i(hmask_q), .imask_i(imask_q), .out_valid, .out_stall,
    .index_o, .collision_o
  );

  // a collision result always carries index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && collision_o |-> index_o == '0)
    else $error("collision with nonzero index");

  // the back end never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(index_o) && $stable(collision_o))
    else $error("stalled result changed");
endmodule

/* src/phl_front.sv */
module phl_front import phl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command_i,
  input  logic [31:0] key_i,
  input  logic [23:0] addr_i,
  input  logic [31:0] value_i,
  input  logic [2:0]  mode_i,
  input  logic [31:0] seed1_i,
  input  logic [31:0] seed2_i,
  input  logic [31:0] seed3_i,
  input  logic [31:0] seed4_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);
  // iterative hasher: 4 CRC steps of 8 bits, or 3 Jenkins rounds
  logic        busy_q, busy_d, done_q, done_d;
  logic [1:0]  step_q, step_d;
  logic [2:0]  mode_q, mode_d;
  logic [31:0] a1_q, b1_q, c1_q, a2_q, b2_q, c2_q;
  logic [31:0] a1_d, b1_d, c1_d, a2_d, b2_d, c2_d;
  logic        cmd_q;
  logic [31:0] wdata_q;
  logic [23:0] waddr_q;
  logic [31:0] k1, k2, h1, h2;
  logic        accept, last;

  function automatic logic [95:0] jround(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
    logic [31:0] x, y, z;
    x = a; y = b; z = c;
    x = x - y - z; x = x ^ (z >> 13);
    y = y - z - x; y = y ^ (x << 8);
    z = z - x - y; z = z ^ (y >> 13);
    return {x, y, z};
  endfunction
  function automatic logic [95:0] jround2(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
    logic [31:0] x, y, z;
    x = a; y = b; z = c;
    x = x - y - z; x = x ^ (z >> 12);
    y = y - z - x; y = y ^ (x << 16);
    z = z - x - y; z = z ^ (y >> 5);
    return {x, y, z};
  endfunction
  function automatic logic [95:0] jround3(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
    logic [31:0] x, y, z;
    x = a; y = b; z = c;
    x = x - y - z; x = x ^ (z >> 3);
    y = y - z - x; y = y ^ (x << 10);
    z = z - x - y; z = z ^ (y >> 15);
    return {x, y, z};
  endfunction

  assign in_stall = busy_q | done_q;
  assign accept   = in_valid & ~in_stall;
  assign last     = (mode_q == MODE_JENK) ? (step_q == 2'd2) : (step_q == 2'd3);

  always_comb begin
    unique case (mode_i)
      MODE_ROTX: begin
        k1 = key_i; k2 = rotl(key_i, seed3_i[4:0]);
      end
      MODE_ROTXY: begin
        k1 = rotr(key_i, seed3_i[4:0]); k2 = rotl(key_i, seed4_i[4:0]);
      end
      MODE_WXYZ: begin
        k1 = rotr(key_i, seed3_i[4:0]); k2 = rotl(key_i, seed3_i[12:8]);
      end
      default: begin
        k1 = key_i; k2 = rotl(key_i, 5'd15);
      end
    endcase
  end

  always_comb begin
    logic [95:0] r1, r2;
    busy_d = busy_q; done_d = done_q; step_d = step_q; mode_d = mode_q;
    a1_d = a1_q; b1_d = b1_q; c1_d = c1_q;
    a2_d = a2_q; b2_d = b2_q; c2_d = c2_q;
    r1 = '0; r2 = '0;
    if (accept) begin
      mode_d = (mode_i > MODE_JENK) ? MODE_ROT15 : mode_i;
      step_d = '0;
      busy_d = (command_i == CMD_LOOKUP);
      done_d = (command_i == CMD_WRITE);
      if (mode_i == MODE_JENK) begin
        a1_d = GOLDEN + key_i; b1_d = GOLDEN; c1_d = seed1_i;
        a2_d = GOLDEN + key_i; b2_d = GOLDEN; c2_d = seed2_i;
      end else begin
        c1_d = seed1_i ^ k1; c2_d = seed2_i ^ k2;
      end
    end else if (busy_q) begin
      if (mode_q == MODE_JENK) begin
        unique case (step_q)
          2'd0: begin r1 = jround(a1_q, b1_q, c1_q); r2 = jround(a2_q, b2_q, c2_q); end
          2'd1: begin r1 = jround2(a1_q, b1_q, c1_q); r2 = jround2(a2_q, b2_q, c2_q); end
          default: begin
            r1 = jround3(a1_q, b1_q, c1_q); r2 = jround3(a2_q, b2_q, c2_q);
          end
        endcase
        {a1_d, b1_d, c1_d} = r1;
        {a2_d, b2_d, c2_d} = r2;
      end else begin
        c1_d = crc8(c1_q); c2_d = crc8(c2_q);
      end
      step_d = step_q + 2'd1;
      if (last) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end else if (done_q && job_ready_i) begin
      done_d = 1'b0;
    end
  end

  always_comb begin
    if (mode_q == MODE_WXYZ) begin
      h1 = rotl(c1_q, seed3_i[20:16]);
      h2 = rotr(c2_q, seed3_i[28:24]);
    end else begin
      h1 = c1_q; h2 = c2_q;
    end
  end

  assign job_valid_o = done_q;
  always_comb begin
    job_o.cmd   = cmd_q;
    // only a lookup can collide; a write carries stale hash state
    job_o.coll  = (cmd_q == CMD_LOOKUP) && (h1 == h2);
    job_o.h1    = h1;
    job_o.h2    = h2;
    job_o.wdata = wdata_q;
    job_o.waddr = waddr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; step_q <= '0; mode_q <= MODE_ROT15;
    end else begin
      busy_q <= busy_d; done_q <= done_d; step_q <= step_d; mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= a1_d; b1_q <= b1_d; c1_q <= c1_d;
    a2_q <= a2_d; b2_q <= b2_d; c2_q <= c2_d;
    if (accept) begin
      cmd_q <= command_i; wdata_q <= value_i; waddr_q <= addr_i;
    end
  end
endmodule

/* src/phl_fifo.sv */
module phl_fifo import phl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output job_t data_o
);
  // two-entry queue
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

/* src/phl_back.sv */
module phl_back import phl_pkg::*; #(
  parameter int unsigned AW = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_pop_o,
  input  job_t        job_i,
  input  logic [15:0] hmask_i,
  input  logic [31:0] imask_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] index_o,
  output logic        collision_o
);
  // phases: idle, read first address, read second address, sum
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [31:0]   tbl [2**AW];
  logic [1:0]    st_q;
  logic [31:0]   rd_q, v1_q;
  logic [AW-1:0] ra_q;
  logic [AW-1:0] a1, a2;
  logic          ov_q;
  logic          out_free;
  logic          res_load;

  assign out_free  = ~ov_q | ~out_stall;
  assign a1 = AW'(job_i.h1 & {16'd0, hmask_i});
  assign a2 = AW'(job_i.h2 & {16'd0, hmask_i});
  assign job_pop_o = job_valid_i &&
                     (((st_q == S_IDLE) &&
                       ((job_i.cmd == CMD_WRITE) || (job_i.coll && out_free))) ||
                      ((st_q == S_SUM) && out_free));
  assign res_load  = job_pop_o && (job_i.cmd == CMD_LOOKUP);

  always_ff @(posedge clk_i) begin
    if (job_pop_o && job_i.cmd == CMD_WRITE) tbl[job_i.waddr[AW-1:0]] <= job_i.wdata;
    rd_q <= tbl[ra_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_q <= 1'b0;
    end else begin
      ov_q <= res_load | (ov_q & out_stall);
      unique case (st_q)
        S_IDLE: if (job_valid_i && job_i.cmd == CMD_LOOKUP && !job_i.coll) begin
          st_q <= S_RD1;
        end
        S_RD1: st_q <= S_RD2;
        S_RD2: st_q <= S_SUM;
        S_SUM: if (out_free) begin
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // lookup without collision pops at the end of S_SUM
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: ra_q <= a1;
      S_RD1:  ra_q <= a2;
      S_RD2:  v1_q <= rd_q;
      default: ;
    endcase
    if (res_load) begin
      if (job_i.coll) begin
        index_o <= '0; collision_o <= 1'b1;
      end else begin
        index_o <= (v1_q + rd_q) & imask_i; collision_o <= 1'b0;
      end
    end
  end

  assign out_valid = ov_q;
endmodule
